// ===== hw/rtl/cpcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcc_pkg
// Shared types and constants for the capture pixel color corrector.
// ----------------------------------------------------------------------------
package cpcc_pkg;

  localparam int unsigned ColorW   = 15;
  localparam int unsigned ChanW    = 5;
  localparam int unsigned WordW    = 18;
  localparam int unsigned PixW     = 16;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned RegIdxW  = 3;

  localparam logic [ChanW-1:0] ChanMask    = 5'h1F;
  localparam logic [7:0]       ShadowDark  = 8'd4;

  typedef enum logic [RegIdxW-1:0] {
    REG_RAW_XOR_MASK  = 3'd0,
    REG_REVERSE_WORD  = 3'd1,
    REG_CHAN_REVERSE  = 3'd2,
    REG_CHAN_INVERT   = 3'd3,
    REG_BLACK_LEVEL   = 3'd4,
    REG_SHADOW_ENABLE = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [ColorW-1:0] raw_xor_mask;
    logic              reverse_whole_word;
    logic [2:0]        channel_reverse;
    logic [2:0]        channel_invert;
    logic [ChanW-1:0]  black_level;
    logic              shadow_enable;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    raw_xor_mask:       15'h0000,
    reverse_whole_word: 1'b0,
    channel_reverse:    3'd7,
    channel_invert:     3'd0,
    black_level:        5'd2,
    shadow_enable:      1'b0
  };

endpackage

// ===== hw/rtl/capture_pixel_color_corrector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_pixel_color_corrector
// Converts captured RGB555 bus words to corrected RGB565 pixels.
// ----------------------------------------------------------------------------
// Pipeline: an accepted capture beat passes the input register, conversion
// logic and output register. Throughput: one beat per cycle while the receiver
// takes pixels; ready is passed back through both stages.
// Reset: pipeline valids clear; config registers load their defaults.
// ----------------------------------------------------------------------------
module capture_pixel_color_corrector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cpcc_pkg::AddrW-1:0]    paddr,
  input  logic [cpcc_pkg::DataW-1:0]    pwdata,
  output logic [cpcc_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  input  logic                          capture_valid_i,
  output logic                          capture_ready_o,
  input  logic [cpcc_pkg::WordW-1:0]    capture_word_i,
  output logic                          pixel_valid_o,
  input  logic                          pixel_ready_i,
  output logic [cpcc_pkg::PixW-1:0]     pixel_rgb565_o
);

  cpcc_pkg::cfg_t cfg;

  logic                        s1_valid_q, out_valid_q;
  logic                        s1_shadow_q;
  logic [cpcc_pkg::ColorW-1:0] s1_color_q;
  logic [cpcc_pkg::PixW-1:0]   pix_d, pix_q;
  logic                        in_take, s1_move, out_ready;

  cpcc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cpcc_core u_core (
    .cfg_i    (cfg),
    .shadow_i (s1_shadow_q),
    .color_i  (s1_color_q),
    .pixel_o  (pix_d)
  );

  assign out_ready       = !out_valid_q || pixel_ready_i;
  assign s1_move         = s1_valid_q && out_ready;
  assign capture_ready_o = !s1_valid_q || out_ready;
  assign in_take         = capture_valid_i && capture_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (capture_ready_o) begin
        s1_valid_q <= capture_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_shadow_q <= capture_word_i[17];
      s1_color_q  <= capture_word_i[16:2];
    end
    if (s1_move) begin
      pix_q <= pix_d;
    end
  end

  assign pixel_valid_o  = out_valid_q;
  assign pixel_rgb565_o = pix_q;

  a_take_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted capture beat did not reach input register");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !capture_ready_o |-> (s1_valid_q && out_valid_q && !pixel_ready_i))
    else $error("input stalled with a free stage");

  a_move_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> (out_valid_q && pix_q == $past(pix_d)))
    else $error("converted pixel not captured in output register");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && pixel_ready_i && !s1_valid_q) |=> !out_valid_q)
    else $error("output beat repeated");

endmodule

// ===== hw/rtl/cpcc_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcc_regs
// APB-style configuration register file; one 32-bit register per word.
// ----------------------------------------------------------------------------
module cpcc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cpcc_pkg::AddrW-1:0]    paddr,
  input  logic [cpcc_pkg::DataW-1:0]    pwdata,
  output logic [cpcc_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output cpcc_pkg::cfg_t                cfg_o
);

  cpcc_pkg::cfg_t     cfg_q, cfg_d;
  cpcc_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = cpcc_pkg::reg_idx_e'(paddr[cpcc_pkg::AddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        cpcc_pkg::REG_RAW_XOR_MASK:  cfg_d.raw_xor_mask       = pwdata[cpcc_pkg::ColorW-1:0];
        cpcc_pkg::REG_REVERSE_WORD:  cfg_d.reverse_whole_word = pwdata[0];
        cpcc_pkg::REG_CHAN_REVERSE:  cfg_d.channel_reverse    = pwdata[2:0];
        cpcc_pkg::REG_CHAN_INVERT:   cfg_d.channel_invert     = pwdata[2:0];
        cpcc_pkg::REG_BLACK_LEVEL:   cfg_d.black_level        = pwdata[cpcc_pkg::ChanW-1:0];
        cpcc_pkg::REG_SHADOW_ENABLE: cfg_d.shadow_enable      = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      cpcc_pkg::REG_RAW_XOR_MASK:  prdata = {17'd0, cfg_q.raw_xor_mask};
      cpcc_pkg::REG_REVERSE_WORD:  prdata = {31'd0, cfg_q.reverse_whole_word};
      cpcc_pkg::REG_CHAN_REVERSE:  prdata = {29'd0, cfg_q.channel_reverse};
      cpcc_pkg::REG_CHAN_INVERT:   prdata = {29'd0, cfg_q.channel_invert};
      cpcc_pkg::REG_BLACK_LEVEL:   prdata = {27'd0, cfg_q.black_level};
      cpcc_pkg::REG_SHADOW_ENABLE: prdata = {31'd0, cfg_q.shadow_enable};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cpcc_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/cpcc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcc_core
// Color correction datapath: mask, reorder, per-channel fix, clamp, shadow.
// ----------------------------------------------------------------------------
module cpcc_core (
  input  cpcc_pkg::cfg_t                  cfg_i,
  input  logic                            shadow_i,
  input  logic [cpcc_pkg::ColorW-1:0]     color_i,
  output logic [cpcc_pkg::PixW-1:0]       pixel_o
);

  function automatic logic [4:0] fix_chan(input logic [4:0] c, input logic rev,
                                          input logic inv);
    logic [4:0] t;
    t = rev ? {c[0], c[1], c[2], c[3], c[4]} : c;
    return inv ? (t ^ cpcc_pkg::ChanMask) : t;
  endfunction

  // halve, widen to 8 bits, subtract with floor at zero
  function automatic logic [7:0] darken(input logic [4:0] c);
    logic [3:0] h;
    logic [7:0] e;
    h = c[4:1];
    e = {1'b0, h, 3'b000} | {6'd0, h[3:2]};
    return (e > cpcc_pkg::ShadowDark) ? (e - cpcc_pkg::ShadowDark) : 8'd0;
  endfunction

  logic [cpcc_pkg::ColorW-1:0] col_x, col;
  logic [4:0] r, g, b;
  logic [7:0] r8, g8, b8;
  logic       dark;

  assign col_x = color_i ^ cfg_i.raw_xor_mask;

  always_comb begin
    col = col_x;
    if (cfg_i.reverse_whole_word) begin
      for (int i = 0; i < cpcc_pkg::ColorW; i++) begin
        col[i] = col_x[cpcc_pkg::ColorW-1-i];
      end
    end
  end

  assign r = fix_chan(col[14:10], cfg_i.channel_reverse[2], cfg_i.channel_invert[2]);
  assign g = fix_chan(col[9:5],   cfg_i.channel_reverse[1], cfg_i.channel_invert[1]);
  assign b = fix_chan(col[4:0],   cfg_i.channel_reverse[0], cfg_i.channel_invert[0]);

  assign r8 = darken(r);
  assign g8 = darken(g);
  assign b8 = darken(b);

  assign dark = (cfg_i.black_level != 5'd0) && (r <= cfg_i.black_level)
                && (g <= cfg_i.black_level) && (b <= cfg_i.black_level);

  always_comb begin
    priority if (shadow_i && cfg_i.shadow_enable) begin
      pixel_o = {r8[7:3], g8[7:2], b8[7:3]};
    end else if (dark) begin
      pixel_o = '0;
    end else begin
      pixel_o = {r, g, g[4], b};
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for capture_pixel_color_corrector. A short directed
// table covers the field extremes, the black clamp, the shadow path and the
// register corner cases. Random capture beats follow under a series of
// register settings, with and without sender and receiver stalls. Each pixel
// beat is checked against its table value or an in-bench color correction model.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned BlockBeats  = 50;
  localparam int unsigned NumBlocks   = 15;
  localparam int unsigned DrainCycles = 4;

  localparam logic [cpcc_pkg::RegIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [cpcc_pkg::RegIdxW-1:0] RegSpareHi = 3'd7;

  typedef struct {
    int unsigned                cfg_sel;
    logic [cpcc_pkg::WordW-1:0] word;
    bit                         typed;
    logic [cpcc_pkg::PixW-1:0]  pix;
  } capture_row_t;

  typedef struct {
    logic [cpcc_pkg::WordW-1:0] word;
    logic [cpcc_pkg::PixW-1:0]  pix;
  } pixel_exp_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [cpcc_pkg::AddrW-1:0]  paddr;
  logic [cpcc_pkg::DataW-1:0]  pwdata;
  logic [cpcc_pkg::DataW-1:0]  prdata;
  logic                        pready;
  logic                        capture_valid_i;
  logic                        capture_ready_o;
  logic [cpcc_pkg::WordW-1:0]  capture_word_i;
  logic                        pixel_valid_o;
  logic                        pixel_ready_i;
  logic [cpcc_pkg::PixW-1:0]   pixel_rgb565_o;

  capture_row_t   dir_rows[$];
  capture_row_t   capture_beat_q[$];
  pixel_exp_t     pixel_exp_q[$];
  cpcc_pkg::cfg_t cfg_now;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;
  int unsigned pixel_cnt;
  int unsigned shadow_cnt;
  int unsigned cfg_cnt;

  capture_row_t seen_beat;
  pixel_exp_t   want;

  capture_pixel_color_corrector uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .capture_valid_i (capture_valid_i),
    .capture_ready_o (capture_ready_o),
    .capture_word_i  (capture_word_i),
    .pixel_valid_o   (pixel_valid_o),
    .pixel_ready_i   (pixel_ready_i),
    .pixel_rgb565_o  (pixel_rgb565_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---- color correction model ----
  function automatic logic [cpcc_pkg::ChanW-1:0] fix_chan(logic [cpcc_pkg::ChanW-1:0] c,
                                                          logic rev, logic inv);
    logic [cpcc_pkg::ChanW-1:0] v;
    v = rev ? {c[0], c[1], c[2], c[3], c[4]} : c;
    return inv ? (v ^ cpcc_pkg::ChanMask) : v;
  endfunction

  function automatic logic [7:0] shade(logic [cpcc_pkg::ChanW-1:0] c);
    logic [cpcc_pkg::ChanW-1:0] h;
    logic [7:0]                 e;
    h = c >> 1;
    e = {h, h[4:2]};
    return (e > cpcc_pkg::ShadowDark) ? (e - cpcc_pkg::ShadowDark) : 8'd0;
  endfunction

  function automatic logic [cpcc_pkg::PixW-1:0] correct_pixel(
      logic [cpcc_pkg::WordW-1:0] word);
    logic [cpcc_pkg::ColorW-1:0] col;
    logic [cpcc_pkg::ColorW-1:0] flipped;
    logic [cpcc_pkg::ChanW-1:0]  r;
    logic [cpcc_pkg::ChanW-1:0]  g;
    logic [cpcc_pkg::ChanW-1:0]  b;
    logic [7:0]                  r8;
    logic [7:0]                  g8;
    logic [7:0]                  b8;
    col = word[16:2] ^ cfg_now.raw_xor_mask;
    for (int i = 0; i < cpcc_pkg::ColorW; i++) flipped[cpcc_pkg::ColorW-1-i] = col[i];
    if (cfg_now.reverse_whole_word) col = flipped;
    r = fix_chan(col[14:10], cfg_now.channel_reverse[2], cfg_now.channel_invert[2]);
    g = fix_chan(col[9:5], cfg_now.channel_reverse[1], cfg_now.channel_invert[1]);
    b = fix_chan(col[4:0], cfg_now.channel_reverse[0], cfg_now.channel_invert[0]);
    if (word[17] && cfg_now.shadow_enable) begin
      r8 = shade(r);
      g8 = shade(g);
      b8 = shade(b);
      return {r8[7:3], g8[7:2], b8[7:3]};
    end
    if (cfg_now.black_level != '0 && r <= cfg_now.black_level &&
        g <= cfg_now.black_level && b <= cfg_now.black_level) begin
      return '0;
    end
    return {r, g, g[4], b};
  endfunction

  // ---- register settings ----
  function automatic cpcc_pkg::cfg_t dir_cfg(int unsigned sel);
    cpcc_pkg::cfg_t c;
    c = '0;
    case (sel)
      0: begin
        c = cpcc_pkg::CfgReset;
      end
      1: begin
        c.shadow_enable = 1'b1;
      end
      2: begin
        c.black_level = 5'd31;
      end
      3: begin
        c = '1;
      end
      4: begin
        c.channel_invert = 3'd7;
      end
      5: begin
        c.reverse_whole_word = 1'b1;
      end
      default: begin
        c.raw_xor_mask = 15'h7FFF;
      end
    endcase
    return c;
  endfunction

  function automatic cpcc_pkg::cfg_t random_cfg();
    cpcc_pkg::cfg_t c;
    logic [31:0]    rnd;
    rnd = $urandom;
    c.raw_xor_mask       = ($urandom_range(3) == 0) ? '0 : rnd[cpcc_pkg::ColorW-1:0];
    c.reverse_whole_word = 1'($urandom_range(1));
    c.channel_reverse    = 3'($urandom_range(7));
    c.channel_invert     = 3'($urandom_range(7));
    case ($urandom_range(3))
      0: rnd = '0;
      1: rnd = $urandom_range(6, 1);
      2: rnd = $urandom_range(31, 12);
      default: rnd = $urandom;
    endcase
    c.black_level   = rnd[cpcc_pkg::ChanW-1:0];
    c.shadow_enable = ($urandom_range(3) != 0);
    return c;
  endfunction

  function automatic logic [cpcc_pkg::WordW-1:0] random_word();
    logic [cpcc_pkg::WordW-1:0] w;
    logic [31:0]                rnd;
    rnd = $urandom;
    w   = rnd[cpcc_pkg::WordW-1:0];
    if ($urandom_range(3) == 0) begin
      for (int ch = 0; ch < 3; ch++) begin
        case ($urandom_range(4))
          0: w[2+5*ch +: 5] = 5'd0;
          1: w[2+5*ch +: 5] = 5'd1;
          2: w[2+5*ch +: 5] = 5'd30;
          3: w[2+5*ch +: 5] = 5'd31;
          default: ;
        endcase
      end
    end
    return w;
  endfunction

  // ---- bus drivers ----
  task automatic write_reg(input logic [cpcc_pkg::RegIdxW-1:0] idx,
                           input logic [cpcc_pkg::DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= cpcc_pkg::AddrW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // upper data bits carry junk; only the register's low bits must stick
  task automatic apply_cfg(input cpcc_pkg::cfg_t c);
    logic [cpcc_pkg::DataW-1:0] junk;
    junk = $urandom;
    write_reg(cpcc_pkg::REG_RAW_XOR_MASK, {junk[31:15], c.raw_xor_mask});
    junk = $urandom;
    write_reg(cpcc_pkg::REG_REVERSE_WORD, {junk[31:1], c.reverse_whole_word});
    junk = $urandom;
    write_reg(cpcc_pkg::REG_CHAN_REVERSE, {junk[31:3], c.channel_reverse});
    junk = $urandom;
    write_reg(cpcc_pkg::REG_CHAN_INVERT, {junk[31:3], c.channel_invert});
    junk = $urandom;
    write_reg(cpcc_pkg::REG_BLACK_LEVEL, {junk[31:5], c.black_level});
    junk = $urandom;
    write_reg(cpcc_pkg::REG_SHADOW_ENABLE, {junk[31:1], c.shadow_enable});
    write_reg(RegSpareLo, $urandom);
    write_reg(RegSpareHi, $urandom);
    cfg_now = c;
    cfg_cnt++;
  endtask

  task automatic send_beat(input capture_row_t r);
    logic [31:0] rnd;
    while ($urandom_range(99) < send_idle_pct) begin
      rnd = $urandom;
      capture_valid_i <= 1'b0;
      capture_word_i  <= rnd[cpcc_pkg::WordW-1:0];
      @(posedge clk_i);
    end
    capture_valid_i <= 1'b1;
    capture_word_i  <= r.word;
    capture_beat_q.push_back(r);
    @(posedge clk_i);
    while (!capture_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    capture_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixel_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic add_row(input int unsigned sel, input logic [cpcc_pkg::WordW-1:0] word,
                         input bit typed, input logic [cpcc_pkg::PixW-1:0] pix);
    capture_row_t r;
    r.cfg_sel = sel;
    r.word    = word;
    r.typed   = typed;
    r.pix     = pix;
    dir_rows.push_back(r);
  endtask

  // ---- receiver and checker ----
  always @(posedge clk_i) begin
    pixel_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pixel_valid_o && pixel_ready_i) begin
        pixel_cnt++;
        if (pixel_exp_q.size() == 0) begin
          $display("%0t: pixel beat %h with no capture pending", $time, pixel_rgb565_o);
          mismatch_cnt++;
        end else begin
          want = pixel_exp_q.pop_front();
          if (pixel_rgb565_o !== want.pix) begin
            $display("%0t: word %h: expected pixel %h, got %h",
                     $time, want.word, want.pix, pixel_rgb565_o);
            mismatch_cnt++;
          end
        end
      end
      if (capture_valid_i && capture_ready_o) begin
        seen_beat = capture_beat_q.pop_front();
        want.word = seen_beat.word;
        want.pix  = seen_beat.typed ? seen_beat.pix : correct_pixel(seen_beat.word);
        if (seen_beat.word[17] && cfg_now.shadow_enable) shadow_cnt++;
        pixel_exp_q.push_back(want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: run stuck, %0d pixels still expected", $time, pixel_exp_q.size());
      $display("capture_pixel_color_corrector test failed");
      $finish;
    end
  end

  // ---- stimulus ----
  initial begin
    int unsigned  cur_sel;
    capture_row_t r;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    capture_valid_i = 1'b0;
    capture_word_i  = '0;
    pixel_ready_i   = 1'b0;
    cycle_cnt       = 0;
    mismatch_cnt    = 0;
    pixel_cnt       = 0;
    shadow_cnt      = 0;
    cfg_cnt         = 0;
    send_idle_pct   = 6;
    recv_idle_pct   = 49;
    cfg_now         = cpcc_pkg::CfgReset;

    // reset defaults: black level 2, all channels bit-reversed
    add_row(0, 18'h00000, 1'b1, 16'h0000);
    add_row(0, 18'h3FFFF, 1'b1, 16'hFFFF);
    add_row(0, 18'h1FFFC, 1'b1, 16'hFFFF);
    add_row(0, 18'h00003, 1'b1, 16'h0000);
    add_row(0, 18'h01084, 1'b0, '0);
    add_row(0, 18'h15554, 1'b0, '0);
    add_row(0, 18'h0AAA8, 1'b0, '0);
    // shadow path on, clamp off
    add_row(1, 18'h20000, 1'b1, 16'h0000);
    add_row(1, 18'h01084, 1'b1, 16'h0841);
    add_row(1, 18'h3FFFC, 1'b0, '0);
    add_row(1, 18'h3FFFF, 1'b0, '0);
    add_row(1, 18'h21084, 1'b0, '0);
    // max black level clamps everything off the shadow path
    add_row(2, 18'h1FFFC, 1'b1, 16'h0000);
    add_row(2, 18'h3FFFF, 1'b1, 16'h0000);
    // every register at its top value, then channel invert, word reverse and xor mask alone
    add_row(3, 18'h3FFFF, 1'b0, '0);
    add_row(3, 18'h00000, 1'b0, '0);
    add_row(3, 18'h2AAAA, 1'b0, '0);
    add_row(3, 18'h15555, 1'b0, '0);
    add_row(4, 18'h00000, 1'b1, 16'hFFFF);
    add_row(4, 18'h1FFFC, 1'b1, 16'h0000);
    add_row(5, 18'h01000, 1'b0, '0);
    add_row(5, 18'h00004, 1'b0, '0);
    add_row(6, 18'h00000, 1'b1, 16'hFFFF);
    add_row(6, 18'h1FFFC, 1'b1, 16'h0000);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_sel = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_sel != cur_sel) begin
        drain();
        cur_sel = dir_rows[i].cfg_sel;
        apply_cfg(dir_cfg(cur_sel));
      end
      send_beat(dir_rows[i]);
    end

    for (int blk = 0; blk < NumBlocks; blk++) begin
      drain();
      if (blk < 5) begin
        send_idle_pct = 6;
        recv_idle_pct = 49;
      end else if (blk < 10) begin
        send_idle_pct = 49;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (blk == 0) apply_cfg('0);
      else if (blk == 1) apply_cfg('1);
      else apply_cfg(random_cfg());
      repeat (BlockBeats) begin
        r.cfg_sel = 0;
        r.word    = random_word();
        r.typed   = 1'b0;
        r.pix     = '0;
        send_beat(r);
      end
    end
    drain();

    $display("Checked %0d pixel beats over %0d register settings, %0d of them shaded.",
             pixel_cnt, cfg_cnt, shadow_cnt);
    $display("Stall mixes: light sender/heavy receiver, the reverse, and none; %0d errors.",
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("capture_pixel_color_corrector test passed");
    end else begin
      $display("capture_pixel_color_corrector test failed");
    end
    $finish;
  end

endmodule
